// File: hw/rtl/ael_pkg.sv
// ----------------------------------------------------------------------------
// ael_pkg
// Shared types and constants of the expression lexer.
// ----------------------------------------------------------------------------
package ael_pkg;

  localparam int unsigned KindW = 5;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [KindW-1:0] K_END   = 5'd0;
  localparam logic [KindW-1:0] K_STR   = 5'd1;
  localparam logic [KindW-1:0] K_NUM   = 5'd10;
  localparam logic [KindW-1:0] K_LABEL = 5'd27;

  localparam logic [ErrW-1:0] E_NONE     = 3'd0;
  localparam logic [ErrW-1:0] E_UNTERM   = 3'd1;
  localparam logic [ErrW-1:0] E_EMPTY    = 3'd2;
  localparam logic [ErrW-1:0] E_LONG     = 3'd3;
  localparam logic [ErrW-1:0] E_CHESC    = 3'd4;
  localparam logic [ErrW-1:0] E_BADINT   = 3'd5;
  localparam logic [ErrW-1:0] E_UNKNOWN  = 3'd6;
  localparam logic [ErrW-1:0] E_STRESC   = 3'd7;

  // Result slot without the numeric value (value travels separately)
  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic             is_num;
    logic [7:0]       ch;
    logic             has_char;
    logic             done;
    logic [ErrW-1:0]  err;
  } slot_t;

  // escape letter to byte; bit 8 set when the letter is a valid escape
  function automatic logic [8:0] escape_val(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h27: r = {1'b1, 8'h27};
      8'h22: r = {1'b1, 8'h22};
      8'h3F: r = {1'b1, 8'h3F};
      8'h5C: r = {1'b1, 8'h5C};
      8'h61: r = {1'b1, 8'h07};
      8'h62: r = {1'b1, 8'h08};
      8'h66: r = {1'b1, 8'h0C};
      8'h6E: r = {1'b1, 8'h0A};
      8'h72: r = {1'b1, 8'h0D};
      8'h74: r = {1'b1, 8'h09};
      8'h76: r = {1'b1, 8'h0B};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = lower(c);
    return is_digit(l) ? l[3:0] : 4'(l - 8'h57);
  endfunction

  // bit0 binary, bit1 octal, bit2 decimal, bit3 hex digit
  function automatic logic [3:0] digit_class(input logic [7:0] c);
    logic [3:0] m;
    m[0] = (c == 8'h30) || (c == 8'h31);
    m[1] = c >= 8'h30 && c <= 8'h37;
    m[2] = is_digit(c);
    m[3] = is_hex(c);
    return m;
  endfunction

endpackage

// File: hw/rtl/ael_if.sv
// ----------------------------------------------------------------------------
// ael_in_if / ael_out_if
// Valid/ready channels of the expression lexer.
// ----------------------------------------------------------------------------
interface ael_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] text_byte;
  modport source (output valid, func, text_byte, input ready);
  modport sink   (input valid, func, text_byte, output ready);
endinterface

interface ael_out_if #(parameter int unsigned VALUE_BITS = 32);
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic [7:0]  text_char;
  logic        has_char;
  logic        token_done;
  logic [2:0]  error_code;
  logic        last;
  modport source (output valid, token_kind, number_value, text_char, has_char,
                  token_done, error_code, last, input ready);
  modport sink   (input valid, token_kind, number_value, text_char, has_char,
                  token_done, error_code, last, output ready);
endinterface

// File: hw/rtl/ael_core.sv
// ----------------------------------------------------------------------------
// ael_core
// Scanner state and next-state logic: one byte in, up to two result slots filled.
// ----------------------------------------------------------------------------
module ael_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [1:0]                   func,
  input  logic [7:0]                   text_byte,
  output ael_pkg::slot_t [2:0]         slots,
  output logic [VALUE_BITS-1:0]        slot_val
);
  import ael_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE, M_PCT, M_PCTNUM, M_AMP, M_PIPE, M_EQ, M_BANG, M_DOL, M_DOLNUM,
    M_LT, M_GT, M_CHOPEN, M_CHESC, M_CHESCQ, M_CHCHAR, M_LABEL, M_NUMBER,
    M_STRING, M_STRESC
  } mode_t;

  localparam int unsigned VW = VALUE_BITS;

  mode_t          mode, mode_next;
  logic [VW-1:0]  bin_v, oct_v, dec_v, hex_v;
  logic [VW-1:0]  bin_next, oct_next, dec_next, hex_next;
  logic [11:0]    flags, flags_next;
  logic [7:0]     chc, chc_next;
  logic           halted, halted_next;

  // emit helpers work on a local copy of the slot list
  slot_t [2:0]    sl;
  logic [1:0]     n;
  logic [VW-1:0]  val;

  logic [7:0]     c;
  logic [3:0]     hv;
  logic [8:0]     esc;
  logic           consumed;
  logic [7:0]     lc;

  assign c    = text_byte;
  assign lc   = lower(c);

  always_comb begin
    slot_t s;
    logic [3:0] m;
    logic [3:0] a, p;
    logic [11:0] f;
    mode_t pm;
    logic [VW-1:0] v0;

    mode_next   = mode;
    bin_next    = bin_v;
    oct_next    = oct_v;
    dec_next    = dec_v;
    hex_next    = hex_v;
    flags_next  = flags;
    chc_next    = chc;
    halted_next = halted;
    sl          = '0;
    n           = 2'd0;
    val         = '0;
    consumed    = 1'b0;
    s           = '0;
    m = '0; a = '0; p = '0; f = '0; pm = M_IDLE; v0 = '0;
    hv = '0; esc = '0;

    if (func == FUNC_START) begin
      mode_next = M_IDLE; bin_next = '0; oct_next = '0; dec_next = '0;
      hex_next = '0; flags_next = '0; chc_next = '0; halted_next = 1'b0;
    end else if (func != FUNC_NONE && !halted) begin
      // ---- continuation of a pending token ----
      if (func == FUNC_BYTE) begin
        unique case (mode)
          M_PCT: if (c == 8'h30 || c == 8'h31) begin
            bin_next = VW'(c[0]); mode_next = M_PCTNUM; consumed = 1'b1;
          end
          M_PCTNUM: if (c == 8'h30 || c == 8'h31) begin
            bin_next = {bin_v[VW-2:0], c[0]}; consumed = 1'b1;
          end
          M_DOL: if (is_hex(c)) begin
            hex_next = VW'(hex_val(c)); mode_next = M_DOLNUM; consumed = 1'b1;
          end
          M_DOLNUM: if (is_hex(c)) begin
            hex_next = {hex_v[VW-5:0], hex_val(c)}; consumed = 1'b1;
          end
          M_AMP: if (c == 8'h26) begin
            s.kind = 5'd11; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_PIPE: if (c == 8'h7C) begin
            s.kind = 5'd14; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_EQ: if (c == 8'h3D) begin
            s.kind = 5'd17; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_BANG: if (c == 8'h3D) begin
            s.kind = 5'd18; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_LT: if (c == 8'h3C || c == 8'h3D) begin
            s.kind = (c == 8'h3C) ? 5'd21 : 5'd22; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_GT: if (c == 8'h3E || c == 8'h3D) begin
            s.kind = (c == 8'h3E) ? 5'd24 : 5'd25; consumed = 1'b1; mode_next = M_IDLE;
          end
          M_CHOPEN: begin
            consumed = 1'b1;
            if (c == 8'h27) s.err = E_EMPTY;
            else if (c == 8'h5C) mode_next = M_CHESC;
            else begin chc_next = c; mode_next = M_CHCHAR; end
          end
          M_CHESC: begin
            consumed = 1'b1; chc_next = c; mode_next = M_CHESCQ;
          end
          M_CHESCQ: begin
            consumed = 1'b1;
            esc = escape_val(chc);
            if (c != 8'h27) s.err = E_LONG;
            else if (!esc[8]) s.err = E_CHESC;
            else begin
              s.kind = K_NUM; s.is_num = 1'b1; val = VW'(esc[7:0]); mode_next = M_IDLE;
            end
          end
          M_CHCHAR: begin
            consumed = 1'b1;
            if (c != 8'h27) s.err = E_LONG;
            else begin
              s.kind = K_NUM; s.is_num = 1'b1; val = VW'(chc); mode_next = M_IDLE;
            end
          end
          M_LABEL: if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
            consumed = 1'b1; s.kind = K_LABEL; s.has_char = 1'b1;
            s.ch = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
          end
          M_NUMBER: if (is_hex(c) || lc == 8'h78 || lc == 8'h68 || lc == 8'h6F) begin
            consumed = 1'b1;
            m = digit_class(lc);
            f = flags;
            f[7:4] = f[3:0];
            f[3:0] = f[3:0] & m;
            if (!f[10]) begin
              f[10] = 1'b1;
              if (f[8] && lc == 8'h78) f[9] = 1'b1;
            end else if (!m[3]) f[9] = 1'b0;
            flags_next = f;
            hv = hex_val(lc);
            if (m[0]) bin_next = {bin_v[VW-2:0], hv[0]};
            if (m[1]) oct_next = {oct_v[VW-4:0], hv[2:0]};
            if (m[2]) dec_next = (dec_v << 3) + (dec_v << 1) + VW'(hv);
            if (m[3]) hex_next = {hex_v[VW-5:0], hv};
            chc_next = lc;
          end
          M_STRING: begin
            consumed = 1'b1;
            if (c == 8'h22) begin s.kind = K_STR; mode_next = M_IDLE; end
            else if (c == 8'h5C) mode_next = M_STRESC;
            else begin s.kind = K_STR; s.ch = c; s.has_char = 1'b1; end
          end
          M_STRESC: begin
            consumed = 1'b1;
            esc = escape_val(c);
            if (!esc[8]) s.err = E_STRESC;
            else begin
              s.kind = K_STR; s.ch = esc[7:0]; s.has_char = 1'b1; mode_next = M_STRING;
            end
          end
          default: ;
        endcase
        if (consumed && mode != M_PCT && mode != M_PCTNUM && mode != M_DOL &&
            mode != M_DOLNUM && mode != M_CHOPEN && mode != M_CHESC &&
            mode != M_NUMBER && !(mode == M_STRING && c == 8'h5C)) begin
          s.valid = 1'b1;
          s.done  = !s.has_char && (s.err == E_NONE);
        end
        if (consumed && mode == M_CHOPEN && c == 8'h27) s.valid = 1'b1;
        if (s.valid && s.err != E_NONE) begin
          s.kind = K_END; s.ch = '0; s.has_char = 1'b0; s.done = 1'b0;
          s.is_num = 1'b0; val = '0; halted_next = 1'b1; mode_next = M_IDLE;
        end
        sl[0] = s;
        n = s.valid ? 2'd1 : 2'd0;
      end

      // ---- flush of the pending token, then end of text or a new token ----
      if (func == FUNC_END || !consumed) begin
        s = '0; s.valid = 1'b1; s.done = 1'b1;
        pm = mode;
        mode_next = M_IDLE;
        a = flags[3:0]; p = flags[7:4];
        unique case (pm)
          M_PCT:    s.kind = 5'd9;
          M_PCTNUM: begin s.kind = K_NUM; s.is_num = 1'b1; val = bin_v; end
          M_AMP:    s.kind = 5'd12;
          M_PIPE:   s.kind = 5'd15;
          M_EQ:     s.kind = 5'd17;
          M_BANG:   s.kind = 5'd19;
          M_DOL:    s.kind = 5'd20;
          M_DOLNUM: begin s.kind = K_NUM; s.is_num = 1'b1; val = hex_v; end
          M_LT:     s.kind = 5'd23;
          M_GT:     s.kind = 5'd26;
          M_CHOPEN, M_CHESC, M_CHESCQ, M_CHCHAR: s.err = E_UNTERM;
          M_LABEL:  s.kind = K_LABEL;
          M_STRING: s.kind = K_STR;
          M_STRESC: s.err = E_STRESC;
          M_NUMBER: begin
            s.kind = K_NUM; s.is_num = 1'b1;
            priority if (p[0] && chc == 8'h62) val = bin_v;
            else if (p[3] && chc == 8'h68) val = hex_v;
            else if (p[1] && chc == 8'h6F) val = oct_v;
            else if (p[2] && chc == 8'h64) val = dec_v;
            else if (flags[8] && a[1]) val = oct_v;
            else if (flags[9] && is_hex(chc)) val = hex_v;
            else if (!flags[8] && a[2]) val = dec_v;
            else s.err = E_BADINT;
          end
          default: s.valid = 1'b0;
        endcase
        if (s.err != E_NONE) begin
          s.kind = K_END; s.done = 1'b0; s.is_num = 1'b0; val = '0;
          halted_next = 1'b1;
        end
        if (s.valid) begin sl[n] = s; n = n + 2'd1; end

        if (s.err == E_NONE) begin
          if (func == FUNC_END) begin
            s = '0; s.valid = 1'b1; s.done = 1'b1; s.kind = K_END;
            sl[n] = s; n = n + 2'd1;
          end else begin
            // byte starts a new token
            s = '0; s.valid = 1'b1; s.done = 1'b1;
            unique case (c)
              8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: s.valid = 1'b0;
              8'h22: begin s.valid = 1'b0; mode_next = M_STRING; end
              8'h28: s.kind = 5'd2;
              8'h29: s.kind = 5'd3;
              8'h2E: s.kind = 5'd4;
              8'h2B: s.kind = 5'd5;
              8'h2D: s.kind = 5'd6;
              8'h2A: s.kind = 5'd7;
              8'h2F: s.kind = 5'd8;
              8'h25: begin s.valid = 1'b0; mode_next = M_PCT; end
              8'h26: begin s.valid = 1'b0; mode_next = M_AMP; end
              8'h5E: s.kind = 5'd13;
              8'h7C: begin s.valid = 1'b0; mode_next = M_PIPE; end
              8'h7E: s.kind = 5'd16;
              8'h3D: begin s.valid = 1'b0; mode_next = M_EQ; end
              8'h21: begin s.valid = 1'b0; mode_next = M_BANG; end
              8'h24: begin s.valid = 1'b0; mode_next = M_DOL; end
              8'h3C: begin s.valid = 1'b0; mode_next = M_LT; end
              8'h3E: begin s.valid = 1'b0; mode_next = M_GT; end
              8'h27: begin s.valid = 1'b0; mode_next = M_CHOPEN; end
              default: begin
                if (is_alpha(c) || c == 8'h5F) begin
                  s.kind = K_LABEL; s.has_char = 1'b1; s.done = 1'b0;
                  s.ch = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
                  mode_next = M_LABEL;
                end else if (is_digit(c)) begin
                  s.valid = 1'b0;
                  m = digit_class(c);
                  flags_next = {3'b000, (c == 8'h30), 4'h0, m};
                  v0 = VW'(c[3:0]);
                  bin_next = m[0] ? v0 : '0;
                  oct_next = m[1] ? v0 : '0;
                  dec_next = v0;
                  hex_next = v0;
                  chc_next = c;
                  mode_next = M_NUMBER;
                end else begin
                  s.kind = K_END; s.done = 1'b0; s.err = E_UNKNOWN;
                  halted_next = 1'b1;
                end
              end
            endcase
            if (s.valid) begin sl[n] = s; n = n + 2'd1; end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; halted <= 1'b0; flags <= '0; chc <= '0;
      bin_v <= '0; oct_v <= '0; dec_v <= '0; hex_v <= '0;
    end else if (step) begin
      mode <= mode_next; halted <= halted_next; flags <= flags_next; chc <= chc_next;
      bin_v <= bin_next; oct_v <= oct_next; dec_v <= dec_next; hex_v <= hex_next;
    end
  end

  assign slots    = sl;
  assign slot_val = val;

endmodule

// File: hw/rtl/assembler_expression_lexer.sv
// ----------------------------------------------------------------------------
// assembler_expression_lexer
// Streaming lexer for assembler expressions: bytes in, tokens out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | request
//  in_ch   | in  | func, text_byte                             | one byte/command
//  out_ch  | out | token_kind, number_value, text_char,        | one token item
//          |     | has_char, token_done, error_code, last      |
//
// One request is scanned in the cycle it is accepted; its up to two results
// sit in a result buffer and leave one per cycle while the output is ready.
// A request that yields one result sustains one per cycle; more results drain first.
// The next request is taken as the last buffered result is taken.
// Reset (rst, synchronous) idles the scanner and empties the buffer.
// A stalled output holds its item; input is held off until the buffer drains.
// ----------------------------------------------------------------------------
module assembler_expression_lexer #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic clk,
  input logic rst,
  ael_in_if.sink                 in_ch,
  ael_out_if.source              out_ch
);
  import ael_pkg::*;

  slot_t [2:0]           slots;
  logic [VALUE_BITS-1:0] slot_val;
  logic                  step;

  // result buffer
  slot_t [2:0]           buf_q;
  logic [VALUE_BITS-1:0] buf_val;
  logic [1:0]            cnt;    // results left
  logic [1:0]            rd;     // next slot to send
  logic                  drain_last;
  logic [1:0]            nslots;

  assign drain_last = (cnt == 2'd0) || (cnt == 2'd1 && out_ch.ready);
  assign in_ch.ready = drain_last;
  assign step = in_ch.valid && in_ch.ready;

  ael_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (in_ch.func),
    .text_byte (in_ch.text_byte),
    .slots     (slots),
    .slot_val  (slot_val)
  );

  assign nslots = 2'(slots[0].valid) + 2'(slots[1].valid) + 2'(slots[2].valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0; rd <= 2'd0;
    end else if (step) begin
      cnt <= nslots; rd <= 2'd0;
    end else if (out_ch.valid && out_ch.ready) begin
      cnt <= cnt - 2'd1; rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      buf_q <= slots; buf_val <= slot_val;
    end
  end

  always_comb begin
    slot_t s;
    s = buf_q[rd];
    out_ch.valid        = cnt != 2'd0;
    out_ch.token_kind   = s.kind;
    // only one number token per request can occur
    out_ch.number_value = s.is_num ? 32'(buf_val) : 32'd0;
    out_ch.text_char    = s.ch;
    out_ch.has_char     = s.has_char;
    out_ch.token_done   = s.done;
    out_ch.error_code   = s.err;
    out_ch.last         = cnt == 2'd1;
  end

endmodule

// File: tb/tb_assembler_expression_lexer.sv
// ----------------------------------------------------------------------------
// tb_assembler_expression_lexer
// Self-checking bench for the streaming expression lexer.
// Text bytes, starts and end-of-text requests are sent through the input
// channel. A behavioural lexer in the bench predicts every token item. Each
// item taken from the output channel is checked field by field against the
// oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_assembler_expression_lexer;
  timeunit 1ns;
  timeprecision 1ps;
  import ael_pkg::*;

  // flag bits of the radix tracker, above the digit-class nibbles
  localparam logic [11:0] RF_ZERO = 12'h100;
  localparam logic [11:0] RF_X    = 12'h200;
  localparam logic [11:0] RF_LEN2 = 12'h400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // scanner states of the behavioural lexer
  typedef enum logic [4:0] {
    SC_IDLE, SC_PCT, SC_PCTNUM, SC_AMP, SC_PIPE, SC_EQ, SC_BANG, SC_DOL,
    SC_DOLNUM, SC_LT, SC_GT, SC_CHOPEN, SC_CHESC, SC_CHESCQ, SC_CHCHAR,
    SC_LABEL, SC_NUMBER, SC_STRING, SC_STRESC
  } scan_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        has_char;
    logic        done;
    logic [2:0]  err;
    logic        last;
  } token_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ael_in_if in_ch ();
  ael_out_if #(.VALUE_BITS(32)) out_ch ();

  assembler_expression_lexer #(.VALUE_BITS(32)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Behavioural lexer: its own copy of the scanner state
  // -------------------------------------------------------------------------
  scan_t       lx_mode;
  logic [31:0] acc_bin, acc_oct, acc_dec, acc_hex;
  logic [11:0] rflags;
  logic [7:0]  held_ch;
  logic        lx_halted;
  int          step_n;

  token_item_t expected_tokens[$];

  int unsigned requests_sent = 0;
  int unsigned tokens_seen   = 0;
  int unsigned mismatches    = 0;
  int unsigned err_seen[8];
  bit          idle_on = 1'b0;

  function automatic bit c_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit c_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit c_hex(logic [7:0] c);
    return c_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] c_low(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function automatic logic [31:0] c_nib(logic [7:0] c);
    logic [7:0] l;
    l = c_low(c);
    return c_dig(l) ? 32'(l - "0") : 32'(l - "a" + 10);
  endfunction

  // escape letter -> byte, bit 8 marks a legal escape
  function automatic logic [8:0] c_esc(logic [7:0] c);
    case (c)
      8'h27, 8'h22, 8'h3F, 8'h5C: return {1'b1, c};
      "a": return {1'b1, 8'h07};
      "b": return {1'b1, 8'h08};
      "f": return {1'b1, 8'h0C};
      "n": return {1'b1, 8'h0A};
      "r": return {1'b1, 8'h0D};
      "t": return {1'b1, 8'h09};
      "v": return {1'b1, 8'h0B};
      default: return 9'd0;
    endcase
  endfunction

  // bit0 binary, bit1 octal, bit2 decimal, bit3 hex
  function automatic logic [3:0] c_class(logic [7:0] c);
    return {c_hex(c), c_dig(c), c >= "0" && c <= "7", c == "0" || c == "1"};
  endfunction

  function automatic void push_tok(logic [4:0] k, logic [31:0] v, logic [7:0] c,
                                   logic h, logic d, logic [2:0] e);
    token_item_t t;
    if (step_n >= 3) return;
    t = '{kind: k, value: v, ch: c, has_char: h, done: d, err: e, last: 1'b0};
    expected_tokens.insert(expected_tokens.size(), t);
    step_n++;
  endfunction

  function automatic void op_tok(logic [4:0] k);
    push_tok(k, 32'd0, 8'd0, 1'b0, 1'b1, E_NONE);
  endfunction

  function automatic void num_tok(logic [31:0] v);
    push_tok(K_NUM, v, 8'd0, 1'b0, 1'b1, E_NONE);
  endfunction

  function automatic void raise(logic [2:0] e);
    push_tok(K_END, 32'd0, 8'd0, 1'b0, 1'b0, e);
    lx_halted = 1'b1;
    lx_mode = SC_IDLE;
  endfunction

  function automatic void label_char(logic [7:0] c);
    push_tok(K_LABEL, 32'd0, (c >= "a" && c <= "z") ? c - 8'd32 : c, 1'b1, 1'b0, E_NONE);
  endfunction

  function automatic void accumulate(logic [7:0] c);
    logic [3:0] m;
    logic [31:0] v;
    m = c_class(c);
    v = c_nib(c);
    if (m[0]) acc_bin = (acc_bin << 1) + v;
    if (m[1]) acc_oct = (acc_oct << 3) + v;
    if (m[2]) acc_dec = acc_dec * 10 + v;
    if (m[3]) acc_hex = (acc_hex << 4) + v;
  endfunction

  function automatic void number_char(logic [7:0] c);
    logic [11:0] f;
    logic [3:0] m;
    m = c_class(c);
    f = rflags;
    f = (f & ~12'h0F0) | {4'd0, f[3:0], 4'd0};
    f = f & ~{8'd0, ~m};
    if (!(f & RF_LEN2)) begin
      f |= RF_LEN2;
      if ((f & RF_ZERO) && c == "x") f |= RF_X;
    end else if (!m[3]) begin
      f &= ~RF_X;
    end
    rflags = f;
    accumulate(c);
    held_ch = c;
  endfunction

  // radix is decided by suffix first, then by the number's shape
  function automatic void number_end();
    logic [3:0] a, p;
    a = rflags[3:0];
    p = rflags[7:4];
    if (p[0] && held_ch == "b") num_tok(acc_bin);
    else if (p[3] && held_ch == "h") num_tok(acc_hex);
    else if (p[1] && held_ch == "o") num_tok(acc_oct);
    else if (p[2] && held_ch == "d") num_tok(acc_dec);
    else if ((rflags & RF_ZERO) && a[1]) num_tok(acc_oct);
    else if ((rflags & RF_X) && c_hex(held_ch)) num_tok(acc_hex);
    else if (!(rflags & RF_ZERO) && a[2]) num_tok(acc_dec);
    else raise(E_BADINT);
  endfunction

  function automatic void close_pending();
    scan_t m;
    m = lx_mode;
    lx_mode = SC_IDLE;
    case (m)
      SC_PCT:    op_tok(5'd9);
      SC_PCTNUM: num_tok(acc_bin);
      SC_AMP:    op_tok(5'd12);
      SC_PIPE:   op_tok(5'd15);
      SC_EQ:     op_tok(5'd17);
      SC_BANG:   op_tok(5'd19);
      SC_DOL:    op_tok(5'd20);
      SC_DOLNUM: num_tok(acc_hex);
      SC_LT:     op_tok(5'd23);
      SC_GT:     op_tok(5'd26);
      SC_CHOPEN, SC_CHESC, SC_CHESCQ, SC_CHCHAR: raise(E_UNTERM);
      SC_LABEL:  op_tok(K_LABEL);
      SC_NUMBER: number_end();
      SC_STRING: op_tok(K_STR);
      SC_STRESC: raise(E_STRESC);
      default: ;
    endcase
  endfunction

  function automatic void begin_token(logic [7:0] c);
    if (c_space(c)) return;
    case (c)
      "\"": lx_mode = SC_STRING;
      "(": op_tok(5'd2);
      ")": op_tok(5'd3);
      ".": op_tok(5'd4);
      "+": op_tok(5'd5);
      "-": op_tok(5'd6);
      "*": op_tok(5'd7);
      "/": op_tok(5'd8);
      "%": lx_mode = SC_PCT;
      "&": lx_mode = SC_AMP;
      "^": op_tok(5'd13);
      "|": lx_mode = SC_PIPE;
      "~": op_tok(5'd16);
      "=": lx_mode = SC_EQ;
      "!": lx_mode = SC_BANG;
      "$": lx_mode = SC_DOL;
      "<": lx_mode = SC_LT;
      ">": lx_mode = SC_GT;
      8'h27: lx_mode = SC_CHOPEN;
      default: begin
        if (c_alpha(c) || c == "_") begin
          label_char(c);
          lx_mode = SC_LABEL;
        end else if (c_dig(c)) begin
          acc_bin = 0; acc_oct = 0; acc_dec = 0; acc_hex = 0;
          rflags = ((c == "0") ? RF_ZERO : 12'h000) | {8'd0, c_class(c)};
          accumulate(c);
          held_ch = c;
          lx_mode = SC_NUMBER;
        end else begin
          raise(E_UNKNOWN);
        end
      end
    endcase
  endfunction

  // returns 1 when the byte was absorbed by the pending token
  function automatic bit extend_token(logic [7:0] c);
    logic [8:0] e;
    case (lx_mode)
      SC_PCT: if (c == "0" || c == "1") begin
        acc_bin = 32'(c - "0"); lx_mode = SC_PCTNUM; return 1;
      end
      SC_PCTNUM: if (c == "0" || c == "1") begin
        acc_bin = (acc_bin << 1) + 32'(c - "0"); return 1;
      end
      SC_DOL: if (c_hex(c)) begin
        acc_hex = c_nib(c); lx_mode = SC_DOLNUM; return 1;
      end
      SC_DOLNUM: if (c_hex(c)) begin
        acc_hex = (acc_hex << 4) + c_nib(c); return 1;
      end
      SC_AMP:  if (c == "&") begin op_tok(5'd11); lx_mode = SC_IDLE; return 1; end
      SC_PIPE: if (c == "|") begin op_tok(5'd14); lx_mode = SC_IDLE; return 1; end
      SC_EQ:   if (c == "=") begin op_tok(5'd17); lx_mode = SC_IDLE; return 1; end
      SC_BANG: if (c == "=") begin op_tok(5'd18); lx_mode = SC_IDLE; return 1; end
      SC_LT: begin
        if (c == "<") begin op_tok(5'd21); lx_mode = SC_IDLE; return 1; end
        if (c == "=") begin op_tok(5'd22); lx_mode = SC_IDLE; return 1; end
      end
      SC_GT: begin
        if (c == ">") begin op_tok(5'd24); lx_mode = SC_IDLE; return 1; end
        if (c == "=") begin op_tok(5'd25); lx_mode = SC_IDLE; return 1; end
      end
      SC_CHOPEN: begin
        if (c == 8'h27) raise(E_EMPTY);
        else if (c == 8'h5C) lx_mode = SC_CHESC;
        else begin held_ch = c; lx_mode = SC_CHCHAR; end
        return 1;
      end
      SC_CHESC: begin
        held_ch = c; lx_mode = SC_CHESCQ; return 1;
      end
      SC_CHESCQ: begin
        // escape letter is only judged once the closing quote is seen
        if (c != 8'h27) raise(E_LONG);
        else begin
          e = c_esc(held_ch);
          if (!e[8]) raise(E_CHESC);
          else begin num_tok({24'd0, e[7:0]}); lx_mode = SC_IDLE; end
        end
        return 1;
      end
      SC_CHCHAR: begin
        if (c != 8'h27) raise(E_LONG);
        else begin num_tok({24'd0, held_ch}); lx_mode = SC_IDLE; end
        return 1;
      end
      SC_LABEL: if (c_alpha(c) || c_dig(c) || c == "_") begin
        label_char(c); return 1;
      end
      SC_NUMBER: if (c_hex(c) || c_low(c) == "x" || c_low(c) == "h" || c_low(c) == "o") begin
        number_char(c_low(c)); return 1;
      end
      SC_STRING: begin
        if (c == "\"") begin op_tok(K_STR); lx_mode = SC_IDLE; end
        else if (c == 8'h5C) lx_mode = SC_STRESC;
        else push_tok(K_STR, 32'd0, c, 1'b1, 1'b0, E_NONE);
        return 1;
      end
      SC_STRESC: begin
        e = c_esc(c);
        if (!e[8]) raise(E_STRESC);
        else begin
          push_tok(K_STR, 32'd0, e[7:0], 1'b1, 1'b0, E_NONE);
          lx_mode = SC_STRING;
        end
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic void lexer_clear();
    lx_mode = SC_IDLE;
    acc_bin = 0; acc_oct = 0; acc_dec = 0; acc_hex = 0;
    rflags = 0;
    held_ch = 0;
    lx_halted = 1'b0;
  endfunction

  function automatic void predict_tokens(func_t f, logic [7:0] c);
    step_n = 0;
    if (f == FUNC_START) begin
      lexer_clear();
      return;
    end
    if (f == FUNC_NONE || lx_halted) return;
    if (f == FUNC_END) begin
      close_pending();
      if (!lx_halted) op_tok(K_END);
      lx_mode = SC_IDLE;
    end else if (!extend_token(c)) begin
      close_pending();
      if (!lx_halted) begin_token(c);
    end
    if (step_n > 0) expected_tokens[$].last = 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Request driver
  // -------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(func_t f, logic [7:0] c);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.text_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // prediction made at the edge that accepts the request
    if (f != FUNC_NONE && !(lx_halted && f != FUNC_START)) requests_sent++;
    predict_tokens(f, c);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_request(FUNC_BYTE, s[i]);
  endtask

  task automatic send_expr(string s);
    send_request(FUNC_START, 8'd0);
    send_text(s);
    send_request(FUNC_END, 8'd0);
  endtask

  // -------------------------------------------------------------------------
  // Output stall and result checker
  // -------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_item_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.token_kind, value: out_ch.number_value,
              ch: out_ch.text_char, has_char: out_ch.has_char,
              done: out_ch.token_done, err: out_ch.error_code, last: out_ch.last};
      tokens_seen++;
      err_seen[got.err]++;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected token item kind=%0d val=%h ch=%h err=%0d",
                   $realtime, got.kind, got.value, got.ch, got.err);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] token mismatch\n  exp kind=%0d val=%h ch=%h has=%b done=%b",
                      " err=%0d last=%b\n  got kind=%0d val=%h ch=%h has=%b done=%b",
                      " err=%0d last=%b"}, $realtime,
                     want.kind, want.value, want.ch, want.has_char, want.done,
                     want.err, want.last, got.kind, got.value, got.ch,
                     got.has_char, got.done, got.err, got.last);
        end
      end
    end
  end

  // Watchdog
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d token items outstanding",
               cycles, expected_tokens.size());
      $display("assembler_expression_lexer test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Random fragment builders
  // -------------------------------------------------------------------------
  function automatic string pick_char(string set);
    return string'(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic string digits(string set, int n);
    string s = "";
    repeat (n) s = {s, pick_char(set)};
    return s;
  endfunction

  function automatic string number_frag();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 5);
    case ($urandom_range(0, 9))
      0: return {digits("01", n), pick_char("bB")};
      1: return {digits("01234567", n), pick_char("oO")};
      2: return {digits("0123456789", n), pick_char("dD")};
      3: return {pick_char("123456789"), digits("0123456789abcdefABCDEF", n), pick_char("hH")};
      4: return {"0", pick_char("xX"), digits("0123456789abcdefABCDEF", n)};
      5: return {"0", digits("01234567", n)};
      6: return {"%", digits("01", n)};
      7: return {"$", digits("0123456789abcdefABCDEF", n)};
      // shapes that are often malformed
      8: return {digits("0123456789abcdefxhoXHO", n + 1)};
      default: return {pick_char("123456789"), digits("0123456789", n)};
    endcase
  endfunction

  function automatic string label_frag();
    string s;
    s = pick_char("abcxyzQRSTZ_");
    return {s, digits("abcdefghijklmnopqrstuvwxyzAZ_0129", $urandom_range(0, 5))};
  endfunction

  function automatic string string_frag();
    string s = "\"";
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0)
        s = {s, "\\", pick_char("'\"?\\abfnrtv")};
      else
        s = {s, pick_char("Hello, world! 09~#@")};
    end
    return {s, "\""};
  endfunction

  function automatic string char_frag();
    if ($urandom_range(0, 2) == 0) return {"'\\", pick_char("'\"?\\abfnrtv"), "'"};
    return {"'", pick_char("aZ09 +\"~_"), "'"};
  endfunction

  function automatic string op_frag();
    case ($urandom_range(0, 6))
      0: return pick_char("().+-*/^~");
      1: return pick_char("&|");
      2: return {pick_char("&|"), pick_char("&|")};
      3: return {pick_char("<>"), pick_char("<>=")};
      4: return {pick_char("=!"), "="};
      5: return pick_char("%$=!<>");
      default: return " ";
    endcase
  endfunction

  // mostly well-formed expressions with random content, some noise
  function automatic string expr_frag();
    string s = "";
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: s = {s, number_frag()};
        5, 6, 7:       s = {s, label_frag()};
        8, 9:          s = {s, string_frag()};
        10, 11:        s = {s, char_frag()};
        12:            s = {s, string'(8'($urandom_range(0, 255)))};
        13:            s = {s, pick_char("\t\n\v\f\r ")};
        default:       s = {s, op_frag()};
      endcase
      if ($urandom_range(0, 2) == 0) s = {s, " "};
    end
    return s;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_operators();
    // every operator, two-character pairs and their one-character fallbacks
    send_expr("()./*+-^~&&&||| ==!=!<<<=<>>>=>$%");
  endtask

  task automatic test_numbers();
    send_expr("101b 17o 99D 0ffh 0x1F 017 123 %10 $fF 4294967296");
    send_expr("09");      // leading zero, not octal
  endtask

  task automatic test_chars_labels_strings();
    send_expr("'a' '\\n' a_z9 \"q\\t\"");
  endtask

  task automatic test_errors();
    send_expr("''");      // empty character constant
    send_expr("'ab'");    // too long
    send_expr("'\\q'");   // bad escape letter
    send_expr("'x");      // unterminated at end of text
    send_expr("\"\\");    // backslash at end of string
    send_expr("\"\\z\""); // bad string escape
    send_expr("@");       // unknown byte
    send_request(FUNC_START, 8'd0);
    send_request(FUNC_BYTE, 8'hFF);
    send_request(FUNC_BYTE, "1");   // ignored while halted
    send_request(FUNC_NONE, 8'hA5); // unused function code
    send_request(FUNC_END, 8'd0);
  endtask

  task automatic test_random(int unsigned target);
    string s;
    int unsigned stop_at;
    stop_at = requests_sent + target;
    while (requests_sent < stop_at) begin
      // long stretches without idling alternate with choppy ones
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: send_request(FUNC_START, 8'($urandom));
        1: send_request(FUNC_NONE, 8'($urandom));
        default: ;
      endcase
      s = expr_frag();
      send_text(s);
      if ($urandom_range(0, 2) != 0) send_request(FUNC_END, 8'($urandom));
    end
    send_request(FUNC_END, 8'd0);
    send_request(FUNC_START, 8'd0);
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_NONE;
    in_ch.text_byte <= 8'd0;
    lexer_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operators();
    test_numbers();
    test_chars_labels_strings();
    idle_on = 1'b1;
    test_errors();
    test_random(300);

    in_ch.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests, %0d token items, %0d error items",
             requests_sent, tokens_seen, tokens_seen - err_seen[0]);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("assembler_expression_lexer test passed");
    end else begin
      $display("assembler_expression_lexer test failed");
    end
    $finish;
  end

endmodule
